>>> sv/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the LZ77 window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int LIT_W = 8;
   localparam int OFF_W = 13;
   localparam int LEN_W = 7;

   localparam logic CMD_LITERAL = 1'b0;
   localparam logic CMD_MATCH   = 1'b1;

   typedef struct packed {
      logic             command;
      logic [LIT_W-1:0] literal_byte;
      logic [OFF_W-1:0] back_offset;
      logic [LEN_W-1:0] match_length;
   } lzwd_req_type;

   typedef struct packed {
      logic [LIT_W-1:0] data_byte;
      logic             last;
      logic             bad_offset;
   } lzwd_rsp_type;

   typedef struct packed {
      logic load_lit;
      logic load_bad;
      logic start_match;
      logic rd_issue;
      logic emit_copy;
   } lzwd_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_literal;
      logic offset_bad;
      logic len_zero;
      logic count_last;
   } lzwd_sts_type;

endpackage

>>> sv/lzwd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lzwd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_datapath
// History ring, pointers, byte counters and the result register.
// ----------------------------------------------------------------------------
module lzwd_datapath #(
   parameter int WINDOW  = 4096,
   parameter int MAX_LEN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lzwd_pkg::lzwd_req_type req_data,
   input  lzwd_pkg::lzwd_cmd_type cmd,
   output lzwd_pkg::lzwd_sts_type sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lzwd_pkg::lzwd_rsp_type rsp_data
);
   import lzwd_pkg::*;

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int SEEN_W = $clog2(WINDOW + 1);
   localparam int EXT_W  = ((SEEN_W > OFF_W) ? SEEN_W : OFF_W) + 1;
   localparam logic [EXT_W-1:0]  WIN_EXT  = EXT_W'(WINDOW);
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WINDOW);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
   localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(MAX_LEN);

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lzwd_rsp_type      rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]  off_ext;
   logic [EXT_W-1:0]  rd_sum;
   logic [EXT_W-1:0]  rd_wrap;
   logic [PTR_W-1:0]  rd_start;
   logic [LEN_W-1:0]  len_capped;
   logic [LIT_W-1:0]  ram_rd_data;
   logic [LIT_W-1:0]  ram_wr_data;
   logic              push;

   assign off_ext = EXT_W'(req_data.back_offset);
   assign rd_sum  = EXT_W'(wp_ff) + WIN_EXT - off_ext;
   assign rd_wrap = (rd_sum >= WIN_EXT) ? (rd_sum - WIN_EXT) : rd_sum;
   assign rd_start = rd_wrap[PTR_W-1:0];
   assign len_capped = (req_data.match_length > LEN_CAP) ? LEN_CAP : req_data.match_length;

   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.is_literal = (req_data.command == CMD_LITERAL);
   assign sts.offset_bad = (req_data.back_offset == '0) || (off_ext > EXT_W'(seen_ff));
   assign sts.len_zero   = (req_data.match_length == '0);
   assign sts.count_last = (count_ff == LEN_W'(1));

   assign push        = cmd.load_lit || cmd.emit_copy;
   assign ram_wr_data = cmd.load_lit ? req_data.literal_byte : ram_rd_data;

   lzwd_ram #(
      .WIDTH (LIT_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      wp_in        = wp_ff;
      rd_in        = rd_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (push) begin
         wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
      end

      if (cmd.start_match) begin
         rd_in    = rd_start;
         count_in = len_capped;
      end else if (cmd.emit_copy) begin
         rd_in    = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end

      priority if (cmd.load_lit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.data_byte  = req_data.literal_byte;
         rsp_data_in.last       = 1'b1;
         rsp_data_in.bad_offset = 1'b0;
      end else if (cmd.load_bad) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.data_byte  = '0;
         rsp_data_in.last       = 1'b1;
         rsp_data_in.bad_offset = 1'b1;
      end else if (cmd.emit_copy) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.data_byte  = ram_rd_data;
         rsp_data_in.last       = sts.count_last;
         rsp_data_in.bad_offset = 1'b0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff       <= rd_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/lzwd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Token sequencer: accepts tokens and steps a match one byte at a time.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lzwd_pkg::lzwd_sts_type sts,
   output lzwd_pkg::lzwd_cmd_type cmd
);
   import lzwd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               priority if (sts.is_literal) begin
                  cmd.load_lit = 1'b1;
               end else if (sts.offset_bad) begin
                  cmd.load_bad = 1'b1;
               end else if (!sts.len_zero) begin
                  cmd.start_match = 1'b1;
                  state_in        = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_copy = 1'b1;
               state_in      = sts.count_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/lz77_window_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_window_decoder_unit
// LZ77 token decoder: literals and back-references over a history ring.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | lzwd_req_type (one token)
//  rsp     | out       | rsp_valid/rsp_stall  | lzwd_rsp_type (one byte)
//
//  A literal or a rejected match is answered from ST_IDLE; each byte of a
//  match steps through ST_READ (the registered read) and ST_EMIT (the write).
//  Reset clears the write pointer, the history byte count and the result
//  valid flag; the ring itself holds no reset value.
//  A stalled result holds in the output register; the next token is taken
//  as soon as that register is free or being taken.
// ----------------------------------------------------------------------------
module lz77_window_decoder_unit #(
   parameter int WINDOW  = 4096,
   parameter int MAX_LEN = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lzwd_pkg::lzwd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lzwd_pkg::lzwd_rsp_type rsp_data
);
   import lzwd_pkg::*;

   lzwd_cmd_type cmd;
   lzwd_sts_type sts;

   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzwd_datapath #(
      .WINDOW  (WINDOW),
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZ77 window decoder. Tokens (literals, valid
// and rejected back-references, zero and overlong lengths, window wrap) are
// sent through the request channel; a local history ring predicts every
// output byte, and each accepted result is compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import lzwd_pkg::*;

   localparam int HIST_DEPTH = 4096;
   localparam int RUN_CAP    = 64;
   localparam int OFF_MAX    = (1 << OFF_W) - 1;
   localparam int LEN_MAX    = (1 << LEN_W) - 1;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lzwd_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lzwd_rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;

   logic [LIT_W-1:0] hist_ring [HIST_DEPTH];
   logic [11:0]      hist_wptr = '0;
   logic [OFF_W-1:0] hist_count = '0;
   lzwd_rsp_type     expected_bytes [$];

   lz77_window_decoder_unit #(
      .WINDOW  (HIST_DEPTH),
      .MAX_LEN (RUN_CAP)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(64'd10_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void append_history(input logic [LIT_W-1:0] b);
      hist_ring[hist_wptr] = b;
      hist_wptr = hist_wptr + 12'd1;
      if (hist_count < HIST_DEPTH)
         hist_count = hist_count + 1'b1;
   endfunction

   function automatic void push_byte_result(input logic [LIT_W-1:0] b, input logic fin,
                                            input logic bad);
      lzwd_rsp_type r;
      r.data_byte  = b;
      r.last       = fin;
      r.bad_offset = bad;
      expected_bytes.push_back(r);
   endfunction

   function automatic void decode_token(input lzwd_req_type tok);
      int unsigned      run;
      logic [11:0]      rd;
      logic [LIT_W-1:0] b;
      if (tok.command == CMD_LITERAL) begin
         append_history(tok.literal_byte);
         push_byte_result(tok.literal_byte, 1'b1, 1'b0);
      end else if (tok.back_offset == '0 || tok.back_offset > hist_count) begin
         push_byte_result('0, 1'b1, 1'b1);
      end else begin
         run = (tok.match_length > RUN_CAP) ? RUN_CAP : tok.match_length;
         for (int unsigned i = 0; i < run; i++) begin
            rd = hist_wptr - tok.back_offset[11:0];
            b  = hist_ring[rd];
            append_history(b);
            push_byte_result(b, (i + 1 == run), 1'b0);
         end
      end
   endfunction

   function automatic lzwd_req_type literal_token(input logic [LIT_W-1:0] b);
      lzwd_req_type t;
      t.command      = CMD_LITERAL;
      t.literal_byte = b;
      t.back_offset  = OFF_W'($urandom_range(0, OFF_MAX));
      t.match_length = LEN_W'($urandom_range(0, LEN_MAX));
      return t;
   endfunction

   function automatic lzwd_req_type match_token(input int unsigned off, input int unsigned len);
      lzwd_req_type t;
      t.command      = CMD_MATCH;
      t.literal_byte = LIT_W'($urandom_range(0, 255));
      t.back_offset  = OFF_W'(off);
      t.match_length = LEN_W'(len);
      return t;
   endfunction

   function automatic lzwd_req_type random_token();
      int unsigned pick;
      int unsigned off;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 30 || hist_count == 0)
         return literal_token(LIT_W'($urandom_range(0, 255)));
      if (pick < 88) begin
         if ($urandom_range(0, 1))
            off = $urandom_range(1, (hist_count < 16) ? hist_count : 16);
         else
            off = $urandom_range(1, hist_count);
         case ($urandom_range(0, 7))
            0:       len = 0;
            1, 2:    len = $urandom_range(17, 64);
            3:       len = $urandom_range(65, LEN_MAX);
            default: len = $urandom_range(1, 16);
         endcase
         return match_token(off, len);
      end
      off = $urandom_range(0, 1) ? 0 : $urandom_range(hist_count + 1, OFF_MAX);
      return match_token(off, $urandom_range(0, LEN_MAX));
   endfunction

   task automatic send_token(input lzwd_req_type tok);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tok;
      do @(posedge clock); while (req_stall);
      decode_token(tok);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic test_empty_history();
      send_token(match_token(1, 4));
      send_token(match_token(0, 1));
      send_token(match_token(OFF_MAX, LEN_MAX));
   endtask

   task automatic test_literals();
      send_token(literal_token(8'h00));
      send_token(literal_token(8'hFF));
      send_token(literal_token(8'hA5));
      send_token(literal_token(8'h5A));
   endtask

   task automatic test_matches();
      send_token(match_token(1, 1));
      send_token(match_token(2, 10));
      send_token(match_token(1, 0));
      wait_drain();
      send_token(match_token(hist_count, RUN_CAP));
      send_token(match_token(3, LEN_MAX));
      send_token(match_token(1, RUN_CAP + 1));
   endtask

   task automatic test_bad_offsets();
      send_token(match_token(0, 5));
      send_token(match_token(hist_count + 1, 3));
      send_token(match_token(HIST_DEPTH, 2));
   endtask

   task automatic test_window_wrap();
      for (int i = 0; i < 64; i++)
         send_token(match_token($urandom_range(1, hist_count), $urandom_range(RUN_CAP, LEN_MAX)));
      send_token(match_token(HIST_DEPTH, 3));
      send_token(match_token(HIST_DEPTH + 1, 3));
   endtask

   task automatic test_random_tokens(input int count);
      for (int i = 0; i < count; i++)
         send_token(random_token());
   endtask

   always @(posedge clock) begin
      lzwd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected item %h", rsp_data));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.data_byte !== want.data_byte)
               report_mismatch($sformatf("data_byte %h, want %h",
                                         rsp_data.data_byte, want.data_byte));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
            if (rsp_data.bad_offset !== want.bad_offset)
               report_mismatch($sformatf("bad_offset %b, want %b",
                                         rsp_data.bad_offset, want.bad_offset));
         end
      end
   end

   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(13, 77);
      test_empty_history();
      test_literals();
      test_matches();
      test_bad_offsets();

      set_idle(77, 13);
      test_window_wrap();
      test_random_tokens(16);
      test_random_tokens(16);

      set_idle(0, 0);
      test_random_tokens(16);

      wait_drain();
      repeat (300) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d items never arrived", expected_bytes.size()));

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
